### design/assert_macros.svh
// assertion macros shared by the design files
// no dependencies; define ASSERT_OFF to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### design/egb_pkg.sv
// types shared by the extended gcd block
// no dependencies
package egb_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV
	} egb_state_t;

endpackage

### design/egb_div_unit.sv
// bit-serial restoring divider with horner-style quotient products
// one quotient bit per cycle; depends on assert_macros.svh
`include "assert_macros.svh"

module egb_div_unit #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	input  logic [DATA_WIDTH-1:0] mul_x,
	input  logic [DATA_WIDTH-1:0] mul_y,
	output logic                  busy,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] remainder,
	output logic [DATA_WIDTH-1:0] prod_x,
	output logic [DATA_WIDTH-1:0] prod_y
);
	localparam int CNT_W = $clog2(DATA_WIDTH + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] dvd_q;
	logic [DATA_WIDTH-1:0] dvs_q;
	logic [DATA_WIDTH-1:0] mx_q;
	logic [DATA_WIDTH-1:0] my_q;
	logic [DATA_WIDTH-1:0] px_q;
	logic [DATA_WIDTH-1:0] py_q;

	logic [DATA_WIDTH-1:0] shifted;
	logic [DATA_WIDTH:0]   diff;
	logic                  qbit;

	// partial remainder stays below the divisor, so it fits in DATA_WIDTH-1 bits
	assign shifted = {rem_q[DATA_WIDTH-2:0], dvd_q[DATA_WIDTH-1]};
	assign diff    = {1'b0, shifted} - {1'b0, dvs_q};
	assign qbit    = ~diff[DATA_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
			mx_q  <= mul_x;
			my_q  <= mul_y;
			px_q  <= '0;
			py_q  <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DATA_WIDTH-1:0] : shifted;
			dvd_q <= {dvd_q[DATA_WIDTH-2:0], qbit};
			// quotient bits arrive msb first: p = 2p + bit*m, all modulo 2^w
			px_q  <= {px_q[DATA_WIDTH-2:0], 1'b0} + (qbit ? mx_q : '0);
			py_q  <= {py_q[DATA_WIDTH-2:0], 1'b0} + (qbit ? my_q : '0);
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign remainder = rem_q;
	assign prod_x    = px_q;
	assign prod_y    = py_q;

	`ASSERT_NEVER(a_start_while_busy, clk, arst_n, start && busy_q)
	`ASSERT_CLK(a_last_bit_done, clk, arst_n,
		(busy_q && !start && cnt_q == CNT_W'(1)) |=> (done_q && !busy_q))
	`ASSERT_CLK(a_rem_below_divisor, clk, arst_n, done_q |-> (rem_q < dvs_q))

endmodule

### design/extended_gcd_bezout_top.sv
// extended gcd with bezout coefficients, one item at a time; uses egb_pkg and egb_div_unit.
// each euclid step is one pass of the bit-serial divider, started from ST_CHECK and ended in ST_DIV;
// an item is accepted only in ST_IDLE, so the next item starts after the last one is finished,
// plus any wait for m_axis_tready on the last result.
// a finished result waits in the output register while the next item runs.
// reset clears the sequencer and the output valid flag only.
`include "assert_macros.svh"

module extended_gcd_bezout_top #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// first_value, second_value
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// common_divisor, coeff_first, coeff_second
	output logic [((3*DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);
	import egb_pkg::*;

	localparam int W      = DATA_WIDTH;
	localparam int OUT_TW = ((3*DATA_WIDTH+7)/8)*8;

	egb_state_t state_q, state_d;

	logic [W-1:0] a_q, b_q, x0_q, x1_q, y0_q, y1_q;
	logic [W-1:0] g_q, cx_q, cy_q;
	logic         out_valid_q;

	logic         accept;
	logic         div_start, div_busy, div_done;
	logic         load_out, do_update;
	logic [W-1:0] rem, px, py;
	logic [W-1:0] ua, ub;
	logic         a_neg, b_neg, fix;
	logic [W-1:0] r_new, px_c, py_c, x_new, y_new;

	assign a_neg = a_q[W-1];
	assign b_neg = b_q[W-1];
	assign ua    = a_neg ? -a_q : a_q;
	assign ub    = b_neg ? -b_q : b_q;

	egb_div_unit #(
		.DATA_WIDTH(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ua),
		.divisor  (ub),
		.mul_x    (x1_q),
		.mul_y    (y1_q),
		.busy     (div_busy),
		.done     (div_done),
		.remainder(rem),
		.prod_x   (px),
		.prod_y   (py)
	);

	// euclidean correction: negative dividend with a remainder bumps q by one
	assign fix   = a_neg && (rem != '0);
	assign r_new = fix ? ub - rem : rem;
	assign px_c  = fix ? px + x1_q : px;
	assign py_c  = fix ? py + y1_q : py;
	// opposite signs negate q, turning x0 - q*x1 into x0 + |q|*x1
	assign x_new = (a_neg ^ b_neg) ? x0_q + px_c : x0_q - px_c;
	assign y_new = (a_neg ^ b_neg) ? y0_q + py_c : y0_q - py_c;

	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		load_out      = 1'b0;
		do_update     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (b_q == '0) begin
					// hold here until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					do_update = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q  <= s_axis_tdata[W-1:0];
			b_q  <= s_axis_tdata[2*W-1:W];
			x0_q <= W'(1);
			x1_q <= '0;
			y0_q <= '0;
			y1_q <= W'(1);
		end else if (do_update) begin
			a_q  <= b_q;
			b_q  <= r_new;
			x0_q <= x1_q;
			x1_q <= x_new;
			y0_q <= y1_q;
			y1_q <= y_new;
		end
		if (load_out) begin
			g_q  <= a_q;
			cx_q <= x0_q;
			cy_q <= y0_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TW'({cy_q, cx_q, g_q});

	`ASSERT_CLK(a_done_only_in_div, clk, arst_n, div_done |-> (state_q == ST_DIV))
	`ASSERT_CLK(a_div_runs_in_div, clk, arst_n, div_busy |-> (state_q == ST_DIV))
	`ASSERT_CLK(a_no_overwrite, clk, arst_n,
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))

endmodule
